// ===== hdl/nqsc_pkg.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nqsc_pkg
// shared widths, types and reset value for the n-queens subproblem counter
// ============================================================================
package nqsc_pkg;

    localparam int MASK_W  = 16;   // width of an occupancy mask on the port
    localparam int DEPTH_W = 5;    // width of the start depth field
    localparam int SIZE_W  = 5;    // width of the board size register
    localparam int COUNT_W = 32;   // width of the solution count

    localparam logic [SIZE_W-1:0] BOARD_SIZE_RESET = 5'd8;

    typedef logic [MASK_W-1:0]  mask_t;
    typedef logic [DEPTH_W-1:0] depth_t;
    typedef logic [SIZE_W-1:0]  size_t;
    typedef logic [COUNT_W-1:0] count_t;

endpackage

// ===== hdl/nqsc_if.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nqsc channel interfaces
// valid/ready channels for subproblem words and result words
// ============================================================================
interface nqsc_req_if
    import nqsc_pkg::*;
;
    logic   valid;
    logic   ready;
    depth_t start_depth;
    mask_t  left_diag_mask;
    mask_t  column_mask;
    mask_t  right_diag_mask;

    modport source (output valid, start_depth, left_diag_mask, column_mask,
                    right_diag_mask, input ready);
    modport sink   (input valid, start_depth, left_diag_mask, column_mask,
                    right_diag_mask, output ready);
endinterface

interface nqsc_rsp_if
    import nqsc_pkg::*;
;
    logic   valid;
    logic   ready;
    count_t solution_count;

    modport source (output valid, solution_count, input ready);
    modport sink   (input valid, solution_count, output ready);
endinterface

// ===== hdl/nqueens_subproblem_counter.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nqueens_subproblem_counter
// counts all complete n-queens placements reachable from a partial placement
// ============================================================================
//
//  channel | direction | word contents
//  --------+-----------+--------------------------------------------------
//  req     | in        | start_depth, left/column/right occupancy masks
//  rsp     | out       | solution_count (saturating, 32 bits)
//  cfg     | in        | board_size (write enable + data, no read-back)
//
//  one word at a time: a placed queen (search node) takes one search step;
//  a backtrack also passes through the pop state, since the row below is
//  fetched through the single registered read port of the stack memory;
//  each word also passes through load, finish and hand-off to the output.
//  reset clears control state only; the stack memory needs no clearing
//  since every row is pushed before it is popped. a stalled output holds
//  the result in its register; the next word is taken meanwhile and waits
//  only at its own hand-off.
//
module nqueens_subproblem_counter
    import nqsc_pkg::*;
#(
    parameter int MAX_BOARD = 16
)(
    input  logic              clk,
    input  logic              rst_n,
    nqsc_req_if.sink          req,
    nqsc_rsp_if.source        rsp,
    input  logic              cfg_we,
    input  logic [SIZE_W-1:0] cfg_wdata
);

    // widths that follow from the largest board and the size field
    localparam int LVL_W = (MAX_BOARD > 1) ? $clog2(MAX_BOARD) : 1;
    localparam int CNT_W = $clog2(MAX_BOARD + 1);
    localparam int CMP_W = SIZE_W + 1;

    // one stack row: masks as seen from that row plus the columns left to try
    typedef struct packed {
        logic [MAX_BOARD-1:0] left;
        logic [MAX_BOARD-1:0] col;
        logic [MAX_BOARD-1:0] right;
        logic [MAX_BOARD-1:0] free;
    } row_t;

    // sequencer codes
    localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for a word
    localparam logic [1:0] ST_RUN  = 2'd1;  // one search step per cycle
    localparam logic [1:0] ST_POP  = 2'd2;  // row below arriving from memory
    localparam logic [1:0] ST_DONE = 2'd3;  // count ready for the output stage

    logic [1:0]           state_reg, state_next;
    size_t                size_reg;
    logic [LVL_W-1:0]     level_reg, level_next;
    logic [CNT_W-1:0]     rows_reg, rows_next;
    logic [MAX_BOARD-1:0] full_reg, full_next;
    row_t                 cur_reg, cur_next;
    count_t               tally_reg, tally_next;
    logic                 out_valid_reg, out_valid_next;
    count_t               out_count_reg, out_count_next;

    // stack memory, one write and one registered read per cycle
    row_t                 stack_mem [MAX_BOARD];
    logic                 mem_we;
    logic [LVL_W-1:0]     mem_waddr;
    row_t                 mem_wdata;
    logic                 mem_re;
    logic [LVL_W-1:0]     mem_raddr;
    row_t                 rd_data_reg;

    // load-time decode of the incoming word
    logic [CMP_W-1:0]     n_cmp;
    logic [CMP_W-1:0]     depth_cmp;
    logic [MAX_BOARD-1:0] full_in;
    logic [MAX_BOARD-1:0] left_in, col_in, right_in;

    // search step
    logic [MAX_BOARD-1:0] pick;
    logic [MAX_BOARD-1:0] free_rest;
    logic [MAX_BOARD-1:0] nl, nc, nr;
    logic [CNT_W-1:0]     level_plus;
    logic                 leaf;
    logic                 accept;

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.solution_count = out_count_reg;

    // effective board size saturates at the largest board
    always_comb
    begin
        if ({1'b0, size_reg} > CMP_W'(MAX_BOARD))
        begin
            n_cmp = CMP_W'(MAX_BOARD);
        end
        else
        begin
            n_cmp = {1'b0, size_reg};
        end
        depth_cmp = {1'b0, req.start_depth};
        for (int i = 0; i < MAX_BOARD; i++)
        begin
            full_in[i] = (CMP_W'(i) < n_cmp);
        end
        // masks lose everything off the board, right mask included
        left_in  = MAX_BOARD'(req.left_diag_mask)  & full_in;
        col_in   = MAX_BOARD'(req.column_mask)     & full_in;
        right_in = MAX_BOARD'(req.right_diag_mask) & full_in;
    end

    // lowest free column and the row it leads to
    assign pick       = cur_reg.free & (~cur_reg.free + MAX_BOARD'(1));
    assign free_rest  = cur_reg.free & (cur_reg.free - MAX_BOARD'(1));
    assign nl         = ((cur_reg.left | pick) << 1) & full_reg;
    assign nc         = (cur_reg.col | pick) & full_reg;
    assign nr         = (cur_reg.right | pick) >> 1;
    assign level_plus = CNT_W'(level_reg) + CNT_W'(1);
    assign leaf       = (level_plus >= rows_reg);

    always_comb
    begin
        state_next     = state_reg;
        level_next     = level_reg;
        rows_next      = rows_reg;
        full_next      = full_reg;
        cur_next       = cur_reg;
        tally_next     = tally_reg;
        out_valid_next = out_valid_reg;
        out_count_next = out_count_reg;
        mem_we         = 1'b0;
        mem_waddr      = level_reg;
        mem_wdata      = cur_reg;
        mem_re         = 1'b0;
        mem_raddr      = level_reg - LVL_W'(1);

        // output stage drains independently of the search
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    full_next  = full_in;
                    level_next = '0;
                    rows_next  = CNT_W'(n_cmp - depth_cmp);
                    cur_next.left  = left_in;
                    cur_next.col   = col_in;
                    cur_next.right = right_in;
                    cur_next.free  = full_in & ~(left_in | col_in | right_in);
                    priority if (depth_cmp > n_cmp)
                    begin
                        // more rows filled than the board has
                        tally_next = '0;
                        state_next = ST_DONE;
                    end
                    else if (depth_cmp == n_cmp)
                    begin
                        // board already full: exactly one placement
                        tally_next = COUNT_W'(1);
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        tally_next = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (cur_reg.free == '0)
                begin
                    if (level_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // backtrack: fetch the row below
                        level_next = level_reg - LVL_W'(1);
                        mem_re     = 1'b1;
                        state_next = ST_POP;
                    end
                end
                else if (leaf)
                begin
                    // last row: each free column is a solution
                    cur_next.free = free_rest;
                    if (tally_reg != '1)
                    begin
                        tally_next = tally_reg + COUNT_W'(1);
                    end
                end
                else
                begin
                    // save this row with the column taken, descend
                    mem_we         = 1'b1;
                    mem_wdata.free = free_rest;
                    level_next     = level_reg + LVL_W'(1);
                    cur_next.left  = nl;
                    cur_next.col   = nc;
                    cur_next.right = nr;
                    cur_next.free  = full_reg & ~(nl | nc | nr);
                end
            end
            ST_POP:
            begin
                cur_next   = rd_data_reg;
                state_next = ST_RUN;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = tally_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            size_reg      <= BOARD_SIZE_RESET;
            level_reg     <= '0;
            tally_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            tally_reg     <= tally_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                size_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        rows_reg      <= rows_next;
        full_reg      <= full_next;
        cur_reg       <= cur_next;
        out_count_reg <= out_count_next;
    end

    // stack memory: push and pop never fall in the same cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            stack_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= stack_mem[mem_raddr];
        end
    end

endmodule

// ===== hdl/nqsc_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nqsc_checker
// port-level checks for the n-queens subproblem counter
// ============================================================================
module nqsc_checker
    import nqsc_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   req_valid,
    input logic   req_ready,
    input logic   rsp_valid,
    input logic   rsp_ready,
    input count_t rsp_count
);

    // a stalled result stays offered
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_count))
        else $error("result changed while stalled");

    // one word at a time: no new word right after one is taken
    a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second word taken while busy");

    // a result never appears the cycle right after a word is taken
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !$rose(rsp_valid))
        else $error("result appeared too early");

endmodule

bind nqueens_subproblem_counter nqsc_checker u_nqsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .rsp_count (rsp.solution_count)
);

// ===== sim/nqueens_subproblem_counter_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// nqueens_subproblem_counter_tb
// self-checking bench: partial placements go in over the request channel and
// every accepted word is scored by a bitboard backtracking predictor, so the
// solution count that comes back can be compared against it in order
// ============================================================================
module nqueens_subproblem_counter_tb;

    import nqsc_pkg::*;

    localparam int MAX_BOARD = 16;
    localparam int CLK_HALF  = 6;      // 12 ns period
    localparam int SETTLE    = 16;     // quiet cycles before a write and at the end

    // one subproblem as it travels on the request channel
    typedef struct packed {
        depth_t start_depth;
        mask_t  left_diag_mask;
        mask_t  column_mask;
        mask_t  right_diag_mask;
    } subproblem_t;

    logic  clk;
    logic  rst_n;
    logic  cfg_we;
    size_t cfg_wdata;

    nqsc_req_if req_ch ();
    nqsc_rsp_if rsp_ch ();

    nqueens_subproblem_counter #(
        .MAX_BOARD (MAX_BOARD)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    subproblem_t pending_words[$];      // waiting to be driven
    count_t      expected_counts[$];    // predicted counts, oldest first
    size_t       board_size_q;          // bench copy of the size register
    int          send_idle_pct;
    int          recv_stall_pct;
    int          mismatch_count = 0;

    // ------------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // size register as the search sees it: anything above the max saturates
    function automatic int unsigned active_size();
        return (board_size_q > MAX_BOARD) ? MAX_BOARD : board_size_q;
    endfunction

    // ------------------------------------------------------------------------
    // predictor: depth-first search over free columns, lowest bit first,
    // with one stack row per board row still to fill
    // ------------------------------------------------------------------------
    function automatic count_t count_solutions(subproblem_t w);
        int unsigned n;
        int unsigned rows;
        int unsigned lvl;
        logic [31:0] full;
        logic [31:0] f;
        logic [31:0] b;
        logic [31:0] lft   [MAX_BOARD];
        logic [31:0] col   [MAX_BOARD];
        logic [31:0] rgt   [MAX_BOARD];
        logic [31:0] avail [MAX_BOARD];
        count_t      total;
        bit          done;
        n     = active_size();
        full  = (32'd1 << n) - 32'd1;
        total = '0;
        done  = 1'b0;
        if (w.start_depth > n)
        begin
            total = '0;
        end
        else if (w.start_depth == n)
        begin
            total = 1;
        end
        else
        begin
            rows     = n - w.start_depth;
            lvl      = 0;
            // off-board mask bits are dropped before anything shifts
            lft[0]   = {16'd0, w.left_diag_mask} & full;
            col[0]   = {16'd0, w.column_mask} & full;
            rgt[0]   = {16'd0, w.right_diag_mask} & full;
            avail[0] = full & ~(lft[0] | col[0] | rgt[0]);
            while (!done)
            begin
                f = avail[lvl];
                if (f == 0)
                begin
                    if (lvl == 0)
                        done = 1'b1;
                    else
                        lvl--;
                end
                else
                begin
                    b          = f & (~f + 32'd1);
                    avail[lvl] = f & (f - 32'd1);
                    if (lvl + 1 >= rows)
                    begin
                        if (total != '1)
                            total++;
                    end
                    else
                    begin
                        lft[lvl+1]   = ((lft[lvl] | b) << 1) & full;
                        col[lvl+1]   = (col[lvl] | b) & full;
                        rgt[lvl+1]   = (rgt[lvl] | b) >> 1;
                        avail[lvl+1] = full & ~(lft[lvl+1] | col[lvl+1] | rgt[lvl+1]);
                        lvl++;
                    end
                end
            end
        end
        return total;
    endfunction

    // ------------------------------------------------------------------------
    // driver: a slot opens when nothing is offered or the offered word
    // is being taken; each accepted word is scored right away
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        subproblem_t w;
        if (!rst_n)
        begin
            req_ch.valid           <= 1'b0;
            req_ch.start_depth     <= '0;
            req_ch.left_diag_mask  <= '0;
            req_ch.column_mask     <= '0;
            req_ch.right_diag_mask <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                w.start_depth     = req_ch.start_depth;
                w.left_diag_mask  = req_ch.left_diag_mask;
                w.column_mask     = req_ch.column_mask;
                w.right_diag_mask = req_ch.right_diag_mask;
                expected_counts   = {expected_counts, count_solutions(w)};
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    w = pending_words.pop_front();
                    req_ch.start_depth     <= w.start_depth;
                    req_ch.left_diag_mask  <= w.left_diag_mask;
                    req_ch.column_mask     <= w.column_mask;
                    req_ch.right_diag_mask <= w.right_diag_mask;
                    req_ch.valid           <= 1'b1;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: random back-pressure, in-order compare of result words
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        count_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (expected_counts.size() == 0)
                begin
                    $error("result word with no expectation waiting: solution_count %0d",
                           rsp_ch.solution_count);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_counts.pop_front();
                    if (rsp_ch.solution_count !== want)
                    begin
                        $error("solution_count mismatch: expected %0d, actual %0d",
                               want, rsp_ch.solution_count);
                        mismatch_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    task automatic add_word(input int d, input int l, input int c, input int r);
        subproblem_t w;
        w.start_depth     = depth_t'(d);
        w.left_diag_mask  = mask_t'(l);
        w.column_mask     = mask_t'(c);
        w.right_diag_mask = mask_t'(r);
        pending_words     = {pending_words, w};
    endtask

    // wait until every queued word is in and every count is back
    task automatic drain();
        while (pending_words.size() != 0 || req_ch.valid || expected_counts.size() != 0)
            @(posedge clk);
    endtask

    // size writes only happen with the block idle
    task automatic write_board_size(input int v);
        drain();
        repeat (SETTLE) @(posedge clk);
        cfg_we       <= 1'b1;
        cfg_wdata    <= size_t'(v);
        board_size_q  = size_t'(v);
        @(posedge clk);
        cfg_we       <= 1'b0;
    endtask

    task automatic set_idling(input int mode);
        case (mode % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            default: begin send_idle_pct = 34; recv_stall_pct = 34; end
        endcase
    endtask

    // mostly legal partial placements built queen by queen, some raw noise;
    // larger boards keep only a few rows open so each search stays short
    task automatic send_random_words(input int count);
        int unsigned n;
        int unsigned d;
        int unsigned rows_left;
        int unsigned pick;
        int unsigned i;
        int unsigned k;
        logic [31:0] full;
        logic [31:0] open;
        logic [31:0] b;
        logic [31:0] l;
        logic [31:0] c;
        logic [31:0] r;
        bit          found;
        for (i = 0; i < count; i++)
        begin
            n    = active_size();
            full = (32'd1 << n) - 32'd1;
            if ($urandom_range(99) < 75)
            begin
                if (n <= 8)
                    rows_left = $urandom_range(0, n);
                else
                    rows_left = $urandom_range(0, (n <= 10) ? 5 : 4);
                d = n - rows_left;
                l = 0;
                c = 0;
                r = 0;
                // a dead end just leaves no free column on the next row
                for (k = 0; k < d && (full & ~(l | c | r)) != 0; k++)
                begin
                    open  = full & ~(l | c | r);
                    pick  = $urandom_range(0, $countones(open) - 1);
                    b     = 0;
                    found = 1'b0;
                    for (int j = 0; j < MAX_BOARD; j++)
                    begin
                        if (open[j] && !found)
                        begin
                            if (pick == 0)
                            begin
                                b     = 32'd1 << j;
                                found = 1'b1;
                            end
                            else
                            begin
                                pick--;
                            end
                        end
                    end
                    l = ((l | b) << 1) & full;
                    c = c | b;
                    r = (r | b) >> 1;
                end
                // junk above the board edge must not change the count
                if ($urandom_range(1))
                begin
                    l = l | ({16'd0, 16'($urandom)} & ~full);
                    c = c | ({16'd0, 16'($urandom)} & ~full);
                    r = r | ({16'd0, 16'($urandom)} & ~full);
                end
            end
            else
            begin
                d = $urandom_range(3) == 0 ? $urandom_range(0, 31) : $urandom_range(0, n + 1);
                if (n > 8 && d < n && n - d > 4)
                    d = n - $urandom_range(0, 4);
                l = $urandom;
                c = $urandom;
                r = $urandom;
            end
            add_word(d, l[15:0], c[15:0], r[15:0]);
        end
        drain();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int sizes[13];
        rst_n                  = 1'b0;
        cfg_we                 = 1'b0;
        cfg_wdata              = '0;
        board_size_q           = BOARD_SIZE_RESET;
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        sizes = '{5, 8, 12, 16, 1, 10, 31, 6, 0, 9, 14, 7, 20};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size of 8, no write yet
        set_idling(0);
        add_word(0, 16'h0000, 16'h0000, 16'h0000);      // full 8-board
        add_word(8, 16'h0000, 16'h0000, 16'h0000);      // depth equals size
        add_word(9, 16'h0000, 16'h0000, 16'h0000);      // depth past size
        add_word(31, 16'hFFFF, 16'hFFFF, 16'hFFFF);     // deepest depth code
        add_word(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);      // nothing free
        add_word(0, 16'hFF00, 16'hFF00, 16'hFF00);      // off-board bits only
        add_word(7, 16'h0000, 16'h007F, 16'h0000);      // one column left
        add_word(1, 16'h0002, 16'h0001, 16'h0000);      // queen in column 0
        drain();

        // top of range and a value past it
        set_idling(2);
        write_board_size(MAX_BOARD);
        add_word(16, 16'h0000, 16'h0000, 16'h0000);
        add_word(17, 16'h0000, 16'h0000, 16'h0000);
        add_word(15, 16'h0000, 16'h7FFF, 16'h0000);
        add_word(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_word(14, 16'hFFFF, 16'h0000, 16'h0000);
        write_board_size(31);
        add_word(16, 16'h0000, 16'h0000, 16'h0000);
        add_word(15, 16'h0000, 16'hFFFE, 16'h0000);

        // empty board and the smallest real ones
        set_idling(3);
        write_board_size(0);
        add_word(0, 16'h0000, 16'h0000, 16'h0000);
        add_word(1, 16'h0000, 16'h0000, 16'h0000);
        add_word(0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_board_size(1);
        add_word(0, 16'h0000, 16'h0000, 16'h0000);
        add_word(0, 16'h0000, 16'h0001, 16'h0000);
        add_word(1, 16'h0000, 16'h0000, 16'h0000);
        write_board_size(4);
        add_word(0, 16'h0000, 16'h0000, 16'h0000);
        write_board_size(6);
        add_word(0, 16'h0000, 16'h0000, 16'h0000);
        drain();

        // random phases over a spread of sizes, rotating the idling pattern
        for (int p = 0; p < 13; p++)
        begin
            write_board_size(sizes[p]);
            set_idling(p);
            if (p == 3)
            begin
                // sender holds off mid-phase until all counts are back
                send_random_words(5);
                send_random_words(4);
            end
            else
            begin
                send_random_words(9);
            end
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // ------------------------------------------------------------------------
    // watchdog
    // ------------------------------------------------------------------------
    initial
    begin
        #(60_000_000);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
